FILE: rtl/core/tdtb_pkg.sv
// Shared types, constants and command codes of the tick-driven timer bank.
package tdtb_pkg;

   localparam int NUM_TIMERS     = 8;
   localparam int TICK_PERIOD_MS = 1000;

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   // floor(x / TICK_PERIOD_MS) == (x * DIV_MULT) >> DIV_SHIFT for every 32-bit x
   localparam int DIV_SHIFT  = 32 + $clog2(TICK_PERIOD_MS);
   localparam int DIV_MULT_W = 33;
   localparam int PROD_W     = 32 + DIV_MULT_W;
   localparam logic [DIV_MULT_W-1:0] DIV_MULT =
      DIV_MULT_W'(((64'd1 << DIV_SHIFT) + 64'(TICK_PERIOD_MS) - 64'd1) / 64'(TICK_PERIOD_MS));

   localparam int          CSR_ADDR_W    = 3;
   localparam logic [0:0]  CSR_TIMERS_USE = 1'b0;

   typedef enum logic [3:0] {
      OP_TICK          = 4'd0,
      OP_SET_TRIGGER   = 4'd1,
      OP_RESTART       = 4'd2,
      OP_STOP          = 4'd3,
      OP_PAUSE         = 4'd4,
      OP_RESUME        = 4'd5,
      OP_CLEAR_FLAG    = 4'd6,
      OP_CHECK         = 4'd7,
      OP_ONESHOT_START = 4'd8,
      OP_ONESHOT_CHECK = 4'd9
   } tdtb_op_type;

   typedef enum logic [1:0] {
      KIND_NOP  = 2'd0,
      KIND_TICK = 2'd1,
      KIND_CMD  = 2'd2
   } tdtb_kind_type;

   typedef struct packed {
      tdtb_kind_type kind;
      tdtb_op_type   op;
      logic [2:0]    timer_index;
      logic [31:0]   quotient;
   } tdtb_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_ADV  = 3'b010,
      ST_CMP  = 3'b100
   } tdtb_state_type;

endpackage

FILE: rtl/core/tdtb_if.sv
// Request and response channel interfaces of the timer bank.
interface tdtb_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  op;
   logic [2:0]  timer_index;
   logic [31:0] time_ms;

   modport source (output valid, output op, output timer_index, output time_ms,
                   input ready);
   modport sink   (input valid, input op, input timer_index, input time_ms,
                   output ready);
endinterface

interface tdtb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] fired_mask;
   logic       flag_out;

   modport source (output valid, output fired_mask, output flag_out, input ready);
   modport sink   (input valid, input fired_mask, input flag_out, output ready);
endinterface

FILE: rtl/core/tdtb_front.sv
// Front end: takes request beats, classifies them and scales time_ms to ticks.
module tdtb_front
   import tdtb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   tdtb_req_if.sink     req_bus,
   output logic         push_valid,
   input  logic         push_ready,
   output tdtb_cmd_type push_cmd
);

   logic              s1_valid_ff, s1_valid_in;
   logic [3:0]        s1_op_ff, s1_op_in;
   logic [2:0]        s1_idx_ff, s1_idx_in;
   logic [31:0]       s1_ms_ff, s1_ms_in;
   logic [PROD_W-1:0] prod;
   logic              take;

   assign req_bus.ready = !s1_valid_ff || push_ready;
   assign take          = req_bus.valid && req_bus.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_op_in    = s1_op_ff;
      s1_idx_in   = s1_idx_ff;
      s1_ms_in    = s1_ms_ff;
      if (push_valid && push_ready) begin
         s1_valid_in = 1'b0;
      end
      if (take) begin
         s1_valid_in = 1'b1;
         s1_op_in    = req_bus.op;
         s1_idx_in   = req_bus.timer_index;
         s1_ms_in    = req_bus.time_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_op_ff  <= s1_op_in;
      s1_idx_ff <= s1_idx_in;
      s1_ms_ff  <= s1_ms_in;
   end

   assign prod = PROD_W'(s1_ms_ff) * PROD_W'(DIV_MULT);

   always_comb begin
      push_cmd.op          = tdtb_op_type'(s1_op_ff);
      push_cmd.timer_index = s1_idx_ff;
      push_cmd.quotient    = 32'(prod >> DIV_SHIFT);
      if (push_cmd.op == OP_TICK) begin
         push_cmd.kind = KIND_TICK;
      end else if ((push_cmd.op inside {[OP_SET_TRIGGER:OP_ONESHOT_CHECK]}) &&
                   (32'(s1_idx_ff) < 32'(NUM_TIMERS))) begin
         push_cmd.kind = KIND_CMD;
      end else begin
         push_cmd.kind = KIND_NOP;
      end
   end

   assign push_valid = s1_valid_ff;

endmodule

FILE: rtl/core/tdtb_queue.sv
// Two-entry queue of classified commands between front and back end.
module tdtb_queue
   import tdtb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  tdtb_cmd_type in_cmd,
   output logic         out_valid,
   input  logic         out_ready,
   output tdtb_cmd_type out_cmd
);

   tdtb_cmd_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

FILE: rtl/core/tdtb_back.sv
// Back end: timer state, tick walk over the timers and per-timer commands.
module tdtb_back
   import tdtb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [3:0]   timers_in_use,
   input  logic         cmd_valid,
   output logic         cmd_ready,
   input  tdtb_cmd_type cmd,
   tdtb_rsp_if.source   rsp_bus
);

   logic [31:0] tick_ff [NUM_TIMERS];
   logic [31:0] tick_in [NUM_TIMERS];
   logic [31:0] last_ff [NUM_TIMERS];
   logic [31:0] last_in [NUM_TIMERS];
   logic [31:0] trig_ff [NUM_TIMERS];
   logic [31:0] trig_in [NUM_TIMERS];
   logic [31:0] carry_ff [NUM_TIMERS];
   logic [31:0] carry_in [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] wrap_ff, wrap_in;
   logic [NUM_TIMERS-1:0] flag_ff, flag_in;
   logic [NUM_TIMERS-1:0] run_ff, run_in;

   tdtb_state_type state_ff, state_in;
   logic [IDX_W-1:0] walk_ff, walk_in;
   logic [CNT_W-1:0] limit_ff, limit_in;
   logic [7:0]       mask_ff, mask_in;
   logic [31:0]      adv_tick_ff, adv_tick_in;
   logic [31:0]      adv_carry_ff, adv_carry_in;
   logic             adv_wrap_ff, adv_wrap_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_mask_ff, rsp_mask_in;
   logic             rsp_flag_ff, rsp_flag_in;

   logic             slot_free;
   logic             pop;
   logic [IDX_W-1:0] cidx;
   logic [CNT_W-1:0] use_cnt;
   logic             fire;

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign cmd_ready = (state_ff == ST_IDLE) && slot_free;
   assign pop       = cmd_valid && cmd_ready;
   assign cidx      = IDX_W'(cmd.timer_index);
   assign use_cnt   = (32'(timers_in_use) > 32'(NUM_TIMERS)) ?
                      CNT_W'(NUM_TIMERS) : CNT_W'(timers_in_use);

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.fired_mask = rsp_mask_ff;
   assign rsp_bus.flag_out   = rsp_flag_ff;

   always_comb begin
      adv_tick_in  = tick_ff[walk_ff];
      adv_carry_in = carry_ff[walk_ff];
      adv_wrap_in  = wrap_ff[walk_ff];
      if (run_ff[walk_ff]) begin
         if (wrap_ff[walk_ff]) begin
            adv_tick_in  = tick_ff[walk_ff] + 32'd1;
            adv_carry_in = carry_ff[walk_ff] + 32'd1;
         end else if (tick_ff[walk_ff] != COUNT_MAX) begin
            adv_tick_in = tick_ff[walk_ff] + 32'd1;
         end else begin
            adv_carry_in = 32'd0 - last_ff[walk_ff];
            adv_tick_in  = 32'd0;
            adv_wrap_in  = 1'b1;
         end
      end
   end

   assign fire = ((adv_tick_ff - last_ff[walk_ff]) >= trig_ff[walk_ff]) ||
                 (adv_wrap_ff && (adv_carry_ff >= trig_ff[walk_ff]));

   always_comb begin
      tick_in      = tick_ff;
      last_in      = last_ff;
      trig_in      = trig_ff;
      carry_in     = carry_ff;
      wrap_in      = wrap_ff;
      flag_in      = flag_ff;
      run_in       = run_ff;
      state_in     = state_ff;
      walk_in      = walk_ff;
      limit_in     = limit_ff;
      mask_in      = mask_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_mask_in  = rsp_mask_ff;
      rsp_flag_in  = rsp_flag_ff;

      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               rsp_mask_in = 8'd0;
               rsp_flag_in = 1'b0;
               if (cmd.kind == KIND_TICK) begin
                  walk_in  = '0;
                  limit_in = use_cnt;
                  mask_in  = 8'd0;
                  if (use_cnt == '0) begin
                     rsp_valid_in = 1'b1;
                  end else begin
                     state_in = ST_ADV;
                  end
               end else begin
                  rsp_valid_in = 1'b1;
                  if (cmd.kind == KIND_CMD) begin
                     case (cmd.op)
                        OP_SET_TRIGGER: begin
                           trig_in[cidx] = (cmd.quotient != 32'd0) ? cmd.quotient : 32'd1;
                        end
                        OP_RESTART, OP_STOP, OP_ONESHOT_START: begin
                           tick_in[cidx]  = 32'd0;
                           last_in[cidx]  = 32'd0;
                           carry_in[cidx] = 32'd0;
                           wrap_in[cidx]  = 1'b0;
                           flag_in[cidx]  = 1'b0;
                           run_in[cidx]   = (cmd.op != OP_STOP);
                           if (cmd.op == OP_ONESHOT_START) begin
                              trig_in[cidx] = (cmd.quotient != 32'd0) ?
                                              cmd.quotient - 32'd1 : 32'd1;
                           end
                        end
                        OP_PAUSE:      run_in[cidx]  = 1'b0;
                        OP_RESUME:     run_in[cidx]  = 1'b1;
                        OP_CLEAR_FLAG: flag_in[cidx] = 1'b0;
                        OP_CHECK: begin
                           rsp_flag_in   = flag_ff[cidx];
                           flag_in[cidx] = 1'b0;
                        end
                        OP_ONESHOT_CHECK: begin
                           rsp_flag_in = flag_ff[cidx];
                           if (flag_ff[cidx]) begin
                              flag_in[cidx] = 1'b0;
                              run_in[cidx]  = 1'b0;
                           end
                        end
                        default: ;
                     endcase
                  end
               end
            end
         end
         ST_ADV: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            tick_in[walk_ff] = adv_tick_ff;
            if (fire) begin
               flag_in[walk_ff]  = 1'b1;
               last_in[walk_ff]  = adv_tick_ff;
               wrap_in[walk_ff]  = 1'b0;
               carry_in[walk_ff] = 32'd0;
               mask_in           = mask_ff | (8'(1) << walk_ff);
            end else begin
               wrap_in[walk_ff]  = adv_wrap_ff;
               carry_in[walk_ff] = adv_carry_ff;
            end
            if ((CNT_W'(walk_ff) + CNT_W'(1)) == limit_ff) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_mask_in  = mask_in;
            end else begin
               walk_in  = walk_ff + IDX_W'(1);
               state_in = ST_ADV;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TIMERS; i++) begin
            tick_ff[i]  <= 32'd0;
            last_ff[i]  <= 32'd0;
            trig_ff[i]  <= 32'd0;
            carry_ff[i] <= 32'd0;
         end
         wrap_ff      <= '0;
         flag_ff      <= '0;
         run_ff       <= '0;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         tick_ff      <= tick_in;
         last_ff      <= last_in;
         trig_ff      <= trig_in;
         carry_ff     <= carry_in;
         wrap_ff      <= wrap_in;
         flag_ff      <= flag_in;
         run_ff       <= run_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      walk_ff      <= walk_in;
      limit_ff     <= limit_in;
      mask_ff      <= mask_in;
      adv_tick_ff  <= adv_tick_in;
      adv_carry_ff <= adv_carry_in;
      adv_wrap_ff  <= adv_wrap_in;
      rsp_mask_ff  <= rsp_mask_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

endmodule

FILE: rtl/core/tick_driven_timer_bank_top.sv
// Top level of the tick-driven timer bank: front end, queue, back end, CSR.
//
// Request beats (op, timer_index, time_ms) enter on req_bus; one response beat
// (fired_mask, flag_out) leaves on rsp_bus per request, in request order.
// The front end registers a beat, divides time_ms by the tick period with a
// reciprocal multiply and pushes the classified command into a 2-entry queue.
// A command is handled in the back end's idle state; a tick walks the timers
// below timers_in_use (capped at NUM_TIMERS), each in an advance state and
// then a compare-and-update state. The tick walk sets the sustained rate.
// The timers_in_use register is written over the APB-style csr_ port at byte
// addresses 0 to 3 (paddr bit 2 clear); addresses 4 to 7 read zero and ignore writes.
// Reset clears all timer state, the register and the queue at once.
// A stalled response holds in its output register; the front end and queue
// keep taking up to three more beats before req_bus.ready drops.
module tick_driven_timer_bank_top
   import tdtb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   tdtb_req_if.sink              req_bus,
   tdtb_rsp_if.source            rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [3:0]   tiu_ff, tiu_in;
   logic         push_valid, push_ready;
   tdtb_cmd_type push_cmd;
   logic         pop_valid, pop_ready;
   tdtb_cmd_type pop_cmd;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_TIMERS_USE) ? {28'd0, tiu_ff} : 32'd0;

   always_comb begin
      tiu_in = tiu_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == CSR_TIMERS_USE)) begin
         tiu_in = csr_pwdata[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tiu_ff <= 4'd0;
      end else begin
         tiu_ff <= tiu_in;
      end
   end

   tdtb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   tdtb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_cmd    (push_cmd),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_cmd   (pop_cmd)
   );

   tdtb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .timers_in_use (tiu_ff),
      .cmd_valid     (pop_valid),
      .cmd_ready     (pop_ready),
      .cmd           (pop_cmd),
      .rsp_bus       (rsp_bus)
   );

endmodule
